@@ rtl/core/boxsm_pkg.sv @@
package boxsm_pkg;

   // Frame geometry; the line stores are FRAME_SIZE words deep
   localparam int FRAME_SIZE = 64;
   localparam int POS_W = $clog2(FRAME_SIZE);
   localparam int COORD_W = 6;

   // Pixel format: four unsigned Q4.12 channels, red in the low bits
   localparam int CHAN_W = 16;
   localparam int NUM_LANES = 4;
   localparam int PIX_W = NUM_LANES * CHAN_W;

   // 3x3 mean: the sum of nine channels fits in CHAN_W + 4 bits.
   // Division by nine is a multiply by a rounded-up reciprocal; with a
   // shift of SUM_W + 1 the error term is 1, so the floor is exact.
   localparam int WIN_SIZE = 9;
   localparam int SUM_W = CHAN_W + 4;
   localparam int RECIP_SHIFT = SUM_W + 1;
   localparam int RECIP_W = RECIP_SHIFT - 3;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((2 ** RECIP_SHIFT) / WIN_SIZE + 1);

   // Result queue
   localparam int MAX_RESULTS = 2;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int CNT_W = FIFO_AW + 1;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic a_shift;     // stage A holds a pixel: advance the window
      logic a_add_left;  // third column: left neighbor comes from the raw column 0 value
      logic b_step;      // stage B holds a pixel
      logic b_add_res;   // left neighbor is the result of the previous pixel
   } lane_ctrl_type;

   typedef struct packed {
      coord_type row;
      coord_type column;
      pixel_type pixel;
      logic      last;
   } result_type;

   typedef struct packed {
      logic      step;
      logic      interior;
      logic      border;
      coord_type int_row;
      coord_type int_col;
      pixel_type int_pix;
      coord_type bord_row;
      coord_type bord_col;
      pixel_type bord_pix;
   } push_type;

endpackage

@@ rtl/core/boxsm_req_if.sv @@
interface boxsm_req_if import boxsm_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     frame_start;
   chan_type red;
   chan_type green;
   chan_type blue;
   chan_type alpha;

   modport source (
      output valid,
      output frame_start,
      output red,
      output green,
      output blue,
      output alpha,
      input  ready
   );

   modport sink (
      input  valid,
      input  frame_start,
      input  red,
      input  green,
      input  blue,
      input  alpha,
      output ready
   );
endinterface

@@ rtl/core/boxsm_rsp_if.sv @@
interface boxsm_rsp_if import boxsm_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type row;
   coord_type column;
   chan_type  out_red;
   chan_type  out_green;
   chan_type  out_blue;
   chan_type  out_alpha;
   logic      last_of_run;

   modport source (
      output valid,
      output row,
      output column,
      output out_red,
      output out_green,
      output out_blue,
      output out_alpha,
      output last_of_run,
      input  ready
   );

   modport sink (
      input  valid,
      input  row,
      input  column,
      input  out_red,
      input  out_green,
      input  out_blue,
      input  out_alpha,
      input  last_of_run,
      output ready
   );
endinterface

@@ rtl/core/boxsm_ram.sv @@
module boxsm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/boxsm_lane.sv @@
module boxsm_lane import boxsm_pkg::*; (
   input  logic          clock,
   input  lane_ctrl_type ctrl,
   input  chan_type      px,         // raw pixel of this row
   input  chan_type      old_raw,    // raw pixel of the row above
   input  chan_type      upd_above,  // final pixel two rows up
   output chan_type      res
);
   chan_type upd1_ff, upd2_ff;
   chan_type raw1_ff, raw2_ff;
   chan_type px1_ff, px2_ff;
   chan_type res_ff;
   sum_type  psum_ff, psum_in;
   sum_type  total;
   logic [SUM_W+RECIP_W-1:0] prod;

   // Stage A: everything of the window except the updated left neighbor
   always_comb begin
      psum_in = sum_type'(upd2_ff) + sum_type'(upd1_ff) + sum_type'(upd_above)
              + sum_type'(raw1_ff) + sum_type'(old_raw)
              + sum_type'(px2_ff) + sum_type'(px1_ff) + sum_type'(px);
      if (ctrl.a_add_left) begin
         psum_in = psum_in + sum_type'(raw2_ff);
      end
   end

   // Stage B: closes the loop through the previous result, then divides by nine
   assign total = psum_ff + (ctrl.b_add_res ? sum_type'(res_ff) : '0);
   assign prod  = (SUM_W+RECIP_W)'(total) * (SUM_W+RECIP_W)'(RECIP_MUL);
   assign res   = prod[RECIP_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      if (ctrl.a_shift) begin
         upd2_ff <= upd1_ff;
         upd1_ff <= upd_above;
         raw2_ff <= raw1_ff;
         raw1_ff <= old_raw;
         px2_ff  <= px1_ff;
         px1_ff  <= px;
         psum_ff <= psum_in;
      end
      if (ctrl.b_step) begin
         res_ff <= res;
      end
   end
endmodule

@@ rtl/core/boxsm_merge.sv @@
module boxsm_merge import boxsm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   output logic [CNT_W-1:0]   fill,
   boxsm_rsp_if.source        rsp_chan
);
   result_type slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW-1:0] second_ptr;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         n_push;
   logic               pop;
   result_type         first_res, second_res, head;

   function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
      if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return p + FIFO_AW'(1);
   endfunction

   always_comb begin
      second_res.row    = push.bord_row;
      second_res.column = push.bord_col;
      second_res.pixel  = push.bord_pix;
      second_res.last   = 1'b1;
      if (push.interior) begin
         first_res.row    = push.int_row;
         first_res.column = push.int_col;
         first_res.pixel  = push.int_pix;
         first_res.last   = !push.border;
      end else begin
         first_res = second_res;
      end
      n_push = push.step ? ({1'b0, push.interior} + {1'b0, push.border}) : 2'd0;
   end

   assign second_ptr = ptr_next(wr_ptr_ff);
   assign pop        = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      case (n_push)
         2'd1:    wr_ptr_in = second_ptr;
         2'd2:    wr_ptr_in = ptr_next(second_ptr);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[wr_ptr_ff] <= first_res;
      end
      if (n_push == 2'd2) begin
         slot_ff[second_ptr] <= second_res;
      end
   end

   assign head                 = slot_ff[rd_ptr_ff];
   assign fill                 = count_ff;
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.row         = head.row;
   assign rsp_chan.column      = head.column;
   assign rsp_chan.out_red     = head.pixel[0*CHAN_W +: CHAN_W];
   assign rsp_chan.out_green   = head.pixel[1*CHAN_W +: CHAN_W];
   assign rsp_chan.out_blue    = head.pixel[2*CHAN_W +: CHAN_W];
   assign rsp_chan.out_alpha   = head.pixel[3*CHAN_W +: CHAN_W];
   assign rsp_chan.last_of_run = head.last;

   // the upstream reservation must keep every push within the queue
   assert property (@(posedge clock) disable iff (reset)
      push.step |-> (int'(count_ff) + int'(n_push) <= FIFO_DEPTH))
      else $error("result queue overflow");

   // an interior result that is not last always has its border partner queued behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last_of_run) |-> (count_ff >= CNT_W'(2)))
      else $error("first of a result pair queued alone");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !rsp_chan.last_of_run) |=> (rsp_chan.valid && rsp_chan.last_of_run))
      else $error("result pair split");
endmodule

@@ rtl/core/in_place_box_smoothing_3x3_unit.sv @@
// In-place 3x3 box smoothing of a square FRAME_SIZE x FRAME_SIZE frame of four-channel
// Q4.12 pixels, taken in raster order one transfer per pixel (frame_start restarts the
// position at row 0, column 0). Every interior pixel becomes the truncated mean of its
// neighborhood, where the row above and the left neighbor already hold smoothed values;
// border pixels leave unchanged. Results carry their coordinates and come out of raster
// order: a pixel completes its interior neighbor up and to the left first, then its own
// border copy, with last_of_run on the final one. Four channel lanes run side by side
// and a merge queue of eight entries orders their results. The block accepts one pixel
// per clock while the queue has room; a pixel in the last column or the last row may
// yield two results, and as the result port moves one per clock, a long run of those
// (the last row) is held back by the result port. A pixel passes stage A, then stage B,
// which pushes its results into the queue. The rate is set by the divide-by-nine loop
// in each lane, which feeds each result back, registered, into the next column's sum,
// and by the result port. Two line stores of FRAME_SIZE words (raw and smoothed) supply
// the window; they need no clearing after reset.
module in_place_box_smoothing_3x3_unit import boxsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   boxsm_req_if.sink   req_chan,
   boxsm_rsp_if.source rsp_chan
);
   localparam pos_type LAST_POS = pos_type'(FRAME_SIZE - 1);
   localparam pos_type POS_ONE  = pos_type'(1);
   localparam pos_type POS_TWO  = pos_type'(2);
   localparam int      NEED_W   = CNT_W + 2;

   function automatic coord_type coord_of(input pos_type p);
      logic [POS_W+COORD_W-1:0] wide;
      wide = {{COORD_W{1'b0}}, p};
      return wide[COORD_W-1:0];
   endfunction

   logic          accept;
   pos_type       pos_r, pos_c;
   pos_type       row_ff, row_in, col_ff, col_in;
   logic          interior_in, border_in;
   pixel_type     px_in;

   // stage A: line store data arrives
   logic          a_valid_ff;
   pos_type       a_row_ff, a_col_ff;
   pixel_type     a_px_ff;
   logic          a_interior_ff, a_border_ff;

   // stage B: division and result push
   logic          b_valid_ff;
   pos_type       b_row_ff, b_col_ff;
   pixel_type     b_px_ff, b_old_raw_ff;
   logic          b_interior_ff, b_border_ff;

   pixel_type     raw_rd, upd_rd, upd_above, res_pix;
   pixel_type     lastcol_ff;
   logic          upd_we;
   pos_type       upd_waddr;
   pixel_type     upd_wdata;
   lane_ctrl_type lane_ctrl;
   push_type      push;
   logic [CNT_W-1:0] fill;
   logic [1:0]    n_a, n_b;
   logic [NEED_W-1:0] need;

   assign accept = req_chan.valid && req_chan.ready;
   assign px_in  = {req_chan.alpha, req_chan.blue, req_chan.green, req_chan.red};

   always_comb begin
      pos_r = req_chan.frame_start ? '0 : row_ff;
      pos_c = req_chan.frame_start ? '0 : col_ff;
      interior_in = (pos_r >= POS_TWO) && (pos_c >= POS_TWO);
      border_in   = (pos_r == '0) || (pos_r == LAST_POS) || (pos_c == '0) || (pos_c == LAST_POS);
      row_in = pos_r;
      col_in = pos_c + POS_ONE;
      if (pos_c == LAST_POS) begin
         col_in = '0;
         row_in = (pos_r == LAST_POS) ? '0 : pos_r + POS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_row_ff      <= pos_r;
         a_col_ff      <= pos_c;
         a_px_ff       <= px_in;
         a_interior_ff <= interior_in;
         a_border_ff   <= border_in;
      end
      if (a_valid_ff) begin
         b_row_ff      <= a_row_ff;
         b_col_ff      <= a_col_ff;
         b_px_ff       <= a_px_ff;
         b_old_raw_ff  <= raw_rd;
         b_interior_ff <= a_interior_ff;
         b_border_ff   <= a_border_ff;
      end
      // the last column of the smoothed line is always a raw border value
      if (a_valid_ff && (a_row_ff != '0) && (a_col_ff == LAST_POS)) begin
         lastcol_ff <= raw_rd;
      end
   end

   boxsm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIZE)) raw_line (
      .clock   (clock),
      .wr_en   (a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data (a_px_ff),
      .rd_en   (accept),
      .rd_addr (pos_c),
      .rd_data (raw_rd)
   );

   // smoothed line: row 1 and column 0 take raw values, interior pixels their result
   always_comb begin
      upd_we = b_valid_ff && (b_interior_ff || (b_row_ff == POS_ONE)
               || ((b_row_ff >= POS_TWO) && (b_col_ff == '0)));
      upd_waddr = b_interior_ff ? b_col_ff - POS_ONE : b_col_ff;
      upd_wdata = b_interior_ff ? res_pix : b_old_raw_ff;
   end

   boxsm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIZE)) upd_line (
      .clock   (clock),
      .wr_en   (upd_we),
      .wr_addr (upd_waddr),
      .wr_data (upd_wdata),
      .rd_en   (accept),
      .rd_addr (pos_c),
      .rd_data (upd_rd)
   );

   assign upd_above = (a_col_ff == LAST_POS) ? lastcol_ff : upd_rd;

   always_comb begin
      lane_ctrl.a_shift    = a_valid_ff;
      lane_ctrl.a_add_left = (a_col_ff == POS_TWO);
      lane_ctrl.b_step     = b_valid_ff;
      lane_ctrl.b_add_res  = (b_col_ff > POS_TWO);
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      boxsm_lane lane (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .px        (a_px_ff[i*CHAN_W +: CHAN_W]),
         .old_raw   (raw_rd[i*CHAN_W +: CHAN_W]),
         .upd_above (upd_above[i*CHAN_W +: CHAN_W]),
         .res       (res_pix[i*CHAN_W +: CHAN_W])
      );
   end

   always_comb begin
      push.step     = b_valid_ff;
      push.interior = b_interior_ff;
      push.border   = b_border_ff;
      push.int_row  = coord_of(b_row_ff - POS_ONE);
      push.int_col  = coord_of(b_col_ff - POS_ONE);
      push.int_pix  = res_pix;
      push.bord_row = coord_of(b_row_ff);
      push.bord_col = coord_of(b_col_ff);
      push.bord_pix = b_px_ff;
   end

   boxsm_merge merge (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fill     (fill),
      .rsp_chan (rsp_chan)
   );

   // reserve queue space for everything in flight plus a worst-case new pixel
   always_comb begin
      n_a  = a_valid_ff ? ({1'b0, a_interior_ff} + {1'b0, a_border_ff}) : 2'd0;
      n_b  = b_valid_ff ? ({1'b0, b_interior_ff} + {1'b0, b_border_ff}) : 2'd0;
      need = NEED_W'(fill) + NEED_W'(n_a) + NEED_W'(n_b) + NEED_W'(MAX_RESULTS);
   end

   assign req_chan.ready = !reset && (need <= NEED_W'(FIFO_DEPTH));

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (int'(fill) + int'(n_a) + int'(n_b) <= FIFO_DEPTH))
      else $error("in-flight results exceed queue space");

   // left neighbor comes through the loop, or from raw column 0 in the third column
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_interior_ff) |-> (lane_ctrl.b_add_res || (b_col_ff == POS_TWO)))
      else $error("interior pixel without a left neighbor source");

   assert property (@(posedge clock) disable iff (reset)
      (upd_we && b_interior_ff) |-> ((upd_waddr != '0) && (upd_waddr != LAST_POS)))
      else $error("result written to a border column of the smoothed line");
endmodule

@@ test/tb_in_place_box_smoothing_3x3_unit.sv @@
`timescale 1ns / 1ps

module tb_in_place_box_smoothing_3x3_unit import boxsm_pkg::*; ();

   localparam int RESET_CYCLES = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PERCENT = 9;
   localparam int FRAME_ROWS = 17;

   typedef struct {
      coord_type row;
      coord_type column;
      chan_type  red;
      chan_type  green;
      chan_type  blue;
      chan_type  alpha;
      logic      last;
   } emitted_pixel_type;

   typedef pixel_type window_type [WIN_SIZE];

   logic clock = 1'b0;
   logic reset = 1'b1;

   boxsm_req_if req_chan ();
   boxsm_rsp_if rsp_chan ();

   in_place_box_smoothing_3x3_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // smoothing state mirrored from the block
   pixel_type smoothed_line [FRAME_SIZE];
   pixel_type raw_line [FRAME_SIZE];
   pixel_type upper_left_smoothed;
   pixel_type left_raw;
   int        pixel_row;
   int        pixel_col;

   emitted_pixel_type pending_pixels [$];

   int  error_count = 0;
   int  pixels_sent = 0;
   int  frame_starts = 0;
   int  results_checked = 0;
   int  interior_checked = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   bit  hold_req = 1'b0;
   int  hold_left = 0;

   function automatic pixel_type neighborhood_mean(input window_type win);
      pixel_type  mean;
      sum_type    lane_sum;
      mean = '0;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         lane_sum = '0;
         for (int i = 0; i < WIN_SIZE; i++)
            lane_sum += sum_type'(win[i][lane*CHAN_W +: CHAN_W]);
         mean[lane*CHAN_W +: CHAN_W] = chan_type'(lane_sum / WIN_SIZE);
      end
      return mean;
   endfunction

   function automatic emitted_pixel_type make_emitted(input int r, input int c,
                                                      input pixel_type px);
      emitted_pixel_type e;
      e.row = coord_type'(r);
      e.column = coord_type'(c);
      e.red = px[0*CHAN_W +: CHAN_W];
      e.green = px[1*CHAN_W +: CHAN_W];
      e.blue = px[2*CHAN_W +: CHAN_W];
      e.alpha = px[3*CHAN_W +: CHAN_W];
      e.last = 1'b0;
      return e;
   endfunction

   // Works out the results of one accepted pixel and queues them.
   task automatic smooth_pixel(input logic fs, input pixel_type px);
      emitted_pixel_type outs [$];
      pixel_type      old_raw;
      pixel_type      mean;
      window_type     win;
      int             r;
      int             c;
      int             x;
      if (fs) begin
         pixel_row = 0;
         pixel_col = 0;
      end
      r = pixel_row;
      c = pixel_col;
      old_raw = raw_line[c];
      if (r == 1) begin
         // row 0 is border, so its smoothed values are its raw values
         smoothed_line[c] = old_raw;
      end else if (r >= 2) begin
         if (c == 0) begin
            upper_left_smoothed = smoothed_line[0];
            smoothed_line[0] = old_raw;
         end else if (c >= 2) begin
            x = c - 1;
            win = '{upper_left_smoothed, smoothed_line[x], smoothed_line[c],
                    smoothed_line[x-1], left_raw, old_raw, raw_line[x-1],
                    raw_line[x], px};
            mean = neighborhood_mean(win);
            outs.push_back(make_emitted(r - 1, x, mean));
            upper_left_smoothed = smoothed_line[x];
            smoothed_line[x] = mean;
            if (c == FRAME_SIZE - 1)
               smoothed_line[c] = old_raw;
         end
      end
      left_raw = old_raw;
      raw_line[c] = px;
      if (r == 0 || r == FRAME_SIZE - 1 || c == 0 || c == FRAME_SIZE - 1)
         outs.push_back(make_emitted(r, c, px));
      if (outs.size() > 0)
         outs[outs.size()-1].last = 1'b1;
      foreach (outs[i])
         pending_pixels.push_back(outs[i]);
      pixel_col = c + 1;
      if (pixel_col >= FRAME_SIZE) begin
         pixel_col = 0;
         pixel_row = (r + 1 >= FRAME_SIZE) ? 0 : r + 1;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_pixel(input logic fs, input pixel_type px);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_start <= fs;
      req_chan.red <= px[0*CHAN_W +: CHAN_W];
      req_chan.green <= px[1*CHAN_W +: CHAN_W];
      req_chan.blue <= px[2*CHAN_W +: CHAN_W];
      req_chan.alpha <= px[3*CHAN_W +: CHAN_W];
      do
         @(posedge clock);
      while (!req_chan.ready);
      smooth_pixel(fs, px);
      pixels_sent++;
      if (fs)
         frame_starts++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // 0..5 random, 6 saturated, 7 black, else each channel one of the extremes or random
   function automatic pixel_type make_pixel(input int mode);
      pixel_type px;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         case (mode)
            6: px[lane*CHAN_W +: CHAN_W] = '1;
            7: px[lane*CHAN_W +: CHAN_W] = '0;
            8, 9: begin
               case ($urandom_range(2))
                  0: px[lane*CHAN_W +: CHAN_W] = '1;
                  1: px[lane*CHAN_W +: CHAN_W] = '0;
                  default: px[lane*CHAN_W +: CHAN_W] = chan_type'($urandom);
               endcase
            end
            default: px[lane*CHAN_W +: CHAN_W] = chan_type'($urandom);
         endcase
      end
      return px;
   endfunction

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      emitted_pixel_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("result at row %0d column %0d with none expected",
                   rsp_chan.row, rsp_chan.column);
            error_count++;
         end else begin
            e = pending_pixels.pop_front();
            check_field("row", e.row, rsp_chan.row);
            check_field("column", e.column, rsp_chan.column);
            check_field("out_red", e.red, rsp_chan.out_red);
            check_field("out_green", e.green, rsp_chan.out_green);
            check_field("out_blue", e.blue, rsp_chan.out_blue);
            check_field("out_alpha", e.alpha, rsp_chan.out_alpha);
            check_field("last_of_run", e.last, rsp_chan.last_of_run);
            results_checked++;
            if (e.row != 0 && e.row != FRAME_SIZE - 1 && e.column != 0 &&
                e.column != FRAME_SIZE - 1)
               interior_checked++;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_in_place_box_smoothing_3x3_unit failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Row 0 only: channel extremes, bit patterns and a restart in mid-row.
   task automatic test_first_row_extremes();
      pixel_type pix [20];
      pix[0] = '0;
      pix[1] = '1;
      pix[2] = {4{16'h5555}};
      pix[3] = {4{16'hAAAA}};
      pix[4] = {16'hFFFE, 16'h7FFF, 16'h8000, 16'h0001};
      pix[5] = {16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
      pix[6] = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
      pix[7] = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
      for (int i = 8; i < 20; i++)
         pix[i] = make_pixel($urandom_range(9));
      pix[11] = '1;
      foreach (pix[i])
         send_pixel(i == 0 || i == 11, pix[i]);
      wait_drained();
   endtask

   // The top rows of a frame with per-row content styles, a long receiver
   // hold-off in the interior and a stretch without idling.
   task automatic test_frame_rows();
      int mode;
      for (int r = 0; r < FRAME_ROWS; r++) begin
         mode = $urandom_range(9);
         idle_on = !(r >= 10 && r < 14);
         for (int c = 0; c < FRAME_SIZE; c++) begin
            if (r == 5 && c == 20)
               hold_req = 1'b1;
            send_pixel(r == 0 && c == 0, make_pixel(mode));
         end
      end
      idle_on = 1'b1;
   endtask

   // Partial frames cut short, with stray frame starts as noise.
   task automatic test_frame_restarts();
      int len;
      repeat (4) begin
         len = $urandom_range(70, 200);
         for (int i = 0; i < len; i++)
            send_pixel(i == 0 || $urandom_range(99) < 2, make_pixel($urandom_range(9)));
      end
      wait_drained();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.frame_start = 1'b0;
      req_chan.red = '0;
      req_chan.green = '0;
      req_chan.blue = '0;
      req_chan.alpha = '0;
      rsp_chan.ready = 1'b0;
      foreach (raw_line[i]) begin
         raw_line[i] = '0;
         smoothed_line[i] = '0;
      end
      upper_left_smoothed = '0;
      left_raw = '0;
      pixel_row = 0;
      pixel_col = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_first_row_extremes();
      test_frame_rows();
      test_frame_restarts();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixels over %0d frame starts: row 0 extremes, %0d frame rows, cut frames.",
               pixels_sent, frame_starts, FRAME_ROWS);
      $display("Checked %0d results, %0d of them smoothed interior pixels.",
               results_checked, interior_checked);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("tb_in_place_box_smoothing_3x3_unit passed");
      end else begin
         $display("tb_in_place_box_smoothing_3x3_unit failed");
      end
      $finish;
   end

endmodule
